// ===== sv/cpd_pkg.sv =====
// Shared types and constants of the command packet deframer.
package cpd_pkg;

	// Largest packet (header, length and payload) that is taken in
	localparam int unsigned MAX_PACKET_LEN = 256;
	// Header bytes plus the two length bytes
	localparam int unsigned HDR_LEN = 5;

	localparam logic [7:0] HDR_BYTE_C  = 8'h43;
	localparam logic [7:0] HDR_BYTE_M  = 8'h4D;
	localparam logic [7:0] HDR_BYTE_GT = 8'h3E;

	localparam logic [7:0] POS_MAX = 8'hFF;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_FIRST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_THIRD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ERR_OK         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ERR_BUSY       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ERR_GENERAL    = 3'd5;

	// Configuration reset values
	localparam logic [15:0] RST_ALLOWED     = 16'd0;
	localparam logic [15:0] RST_ERR_OK      = 16'd0;
	localparam logic [15:0] RST_ERR_BUSY    = 16'd1;
	localparam logic [15:0] RST_ERR_GENERAL = 16'd2;

	// Input item kinds
	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_READY = 2'd1,
		KIND_BUSY  = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	// Verdict carried with each payload byte
	typedef enum logic [1:0] {
		VERDICT_MORE   = 2'd0,
		VERDICT_FWD    = 2'd1,
		VERDICT_REJECT = 2'd2,
		VERDICT_DROP   = 2'd3
	} verdict_t;

	// Configuration register contents
	typedef struct packed {
		logic [15:0] allowed_first;
		logic [15:0] allowed_second;
		logic [15:0] allowed_third;
		logic [15:0] err_ok;
		logic [15:0] err_busy;
		logic [15:0] err_general;
	} cpd_cfg_t;

endpackage

// ===== sv/cpd_cfg_regs.sv =====
// Configuration register file of the command packet deframer.
module cpd_cfg_regs import cpd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	output cpd_cfg_t             cfg
);

	cpd_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Decode the index and write the addressed register; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.allowed_first  <= RST_ALLOWED;
			cfg_q.allowed_second <= RST_ALLOWED;
			cfg_q.allowed_third  <= RST_ALLOWED;
			cfg_q.err_ok         <= RST_ERR_OK;
			cfg_q.err_busy       <= RST_ERR_BUSY;
			cfg_q.err_general    <= RST_ERR_GENERAL;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ALLOWED_FIRST:  cfg_q.allowed_first  <= cfg_data;
				CFG_ALLOWED_SECOND: cfg_q.allowed_second <= cfg_data;
				CFG_ALLOWED_THIRD:  cfg_q.allowed_third  <= cfg_data;
				CFG_ERR_OK:         cfg_q.err_ok         <= cfg_data;
				CFG_ERR_BUSY:       cfg_q.err_busy       <= cfg_data;
				CFG_ERR_GENERAL:    cfg_q.err_general    <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/command_packet_deframer.sv =====
// An accepted item lands in the input register; a payload byte then passes into the
// result register, which drives the output, whenever the path is not stalled.
// Throughput: one item per cycle unless the sink holds off a result; the parser
// update is one step from the input register into the state and result register.
// Reset: arst_n clears the parser to header hunt, the mode to initializing and
// the configuration registers to their reset values; no output item is pending.
module command_packet_deframer import cpd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // data_byte[7:0], err_value[23:8]
	input  logic [1:0]           s_tuser,   // kind[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// payload_byte[7:0], byte_index[15:8], cmd_word[31:16], reject_code[47:32]
	output logic [47:0]          m_tdata,
	output logic [1:0]           m_tuser,   // verdict[1:0]
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	typedef enum logic [2:0] {
		PH_H1  = 3'd0,
		PH_H2  = 3'd1,
		PH_H3  = 3'd2,
		PH_L1  = 3'd3,
		PH_L2  = 3'd4,
		PH_PAY = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		MODE_INIT  = 3'd1,
		MODE_READY = 3'd2,
		MODE_BUSY  = 3'd3,
		MODE_ERROR = 3'd4
	} mode_t;

	cpd_cfg_t cfg;

	cpd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register
	logic        valid_s1;
	kind_t       kind_s1;
	logic [7:0]  byte_s1;
	logic [15:0] ec_s1;

	// Parser and system state
	phase_t      phase_q;
	logic [15:0] left_q;
	logic [7:0]  pos_q;
	logic [15:0] cmd_q;
	mode_t       mode_q;
	logic [15:0] err_q;

	// Result register
	logic        m_tvalid_q;
	logic [7:0]  out_byte_q;
	logic [7:0]  out_idx_q;
	logic        out_last_q;
	verdict_t    out_verdict_q;
	logic [15:0] out_code_q;
	logic [15:0] out_rej_q;

	// Next values
	phase_t      phase_d;
	logic [15:0] left_d;
	logic [7:0]  pos_d;
	logic [15:0] cmd_d;
	mode_t       mode_d;
	logic [15:0] err_d;
	logic        res_valid;
	logic        res_last;
	verdict_t    res_verdict;
	logic [15:0] res_code;
	logic [15:0] res_rej;
	logic [15:0] len_full;
	logic        len_ok;
	logic        two_bytes;
	logic        code_allowed;

	logic advance;
	logic process;

	// Stall the whole path while a result waits and the sink holds off
	assign advance  = !m_tvalid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign process  = valid_s1 && advance;

	assign len_full = {left_q[15:8], byte_s1};
	assign len_ok   = (len_full != 16'd0) &&
		(({1'b0, len_full} + 17'(HDR_LEN)) <= 17'(MAX_PACKET_LEN));
	assign code_allowed = (cmd_d == cfg.allowed_first) || (cmd_d == cfg.allowed_second) ||
		(cmd_d == cfg.allowed_third);
	assign two_bytes = (pos_q != 8'd0);

	// Work out the state update and result for the item in the input register
	always_comb begin
		phase_d     = phase_q;
		left_d      = left_q;
		pos_d       = pos_q;
		cmd_d       = cmd_q;
		mode_d      = mode_q;
		err_d       = err_q;
		res_valid   = 1'b0;
		res_last    = 1'b0;
		res_verdict = VERDICT_MORE;
		res_code    = 16'd0;
		res_rej     = 16'd0;
		unique case (kind_s1)
			KIND_READY: begin
				mode_d = MODE_READY;
				err_d  = cfg.err_ok;
			end
			KIND_BUSY: begin
				mode_d = MODE_BUSY;
				err_d  = cfg.err_busy;
			end
			KIND_ERROR: begin
				mode_d = MODE_ERROR;
				err_d  = (ec_s1 != cfg.err_ok) ? ec_s1 : cfg.err_general;
			end
			default: begin
				unique case (phase_q)
					PH_H1: begin
						if (byte_s1 == HDR_BYTE_C) begin
							phase_d = PH_H2;
						end
					end
					PH_H2: phase_d = (byte_s1 == HDR_BYTE_M) ? PH_H3 : PH_H1;
					PH_H3: phase_d = (byte_s1 == HDR_BYTE_GT) ? PH_L1 : PH_H1;
					PH_L1: begin
						left_d  = {byte_s1, 8'd0};
						phase_d = PH_L2;
					end
					PH_L2: begin
						left_d = len_full;
						if (len_ok) begin
							pos_d   = 8'd0;
							cmd_d   = 16'd0;
							phase_d = PH_PAY;
						end else begin
							phase_d = PH_H1;
						end
					end
					PH_PAY: begin
						// Capture the command code from the first two bytes
						if (pos_q == 8'd0) begin
							cmd_d = {byte_s1, cmd_q[7:0]};
						end else if (pos_q == 8'd1) begin
							cmd_d = {cmd_q[15:8], byte_s1};
						end
						if (pos_q != POS_MAX) begin
							pos_d = pos_q + 8'd1;
						end
						left_d    = left_q - 16'd1;
						res_valid = 1'b1;
						res_last  = (left_d == 16'd0);
						if (res_last) begin
							if (two_bytes) begin
								res_code = cmd_d;
							end
							if (mode_q == MODE_READY || mode_q == MODE_INIT) begin
								res_verdict = VERDICT_FWD;
							end else if (two_bytes) begin
								if (code_allowed) begin
									res_verdict = VERDICT_FWD;
								end else begin
									res_verdict = VERDICT_REJECT;
									res_rej     = err_q;
								end
							end else begin
								res_verdict = VERDICT_DROP;
							end
							phase_d = PH_H1;
						end
					end
					default: phase_d = PH_H1;
				endcase
			end
		endcase
	end

	// Hold the input item until the path advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= kind_t'(s_tuser);
			byte_s1 <= s_tdata[7:0];
			ec_s1   <= s_tdata[23:8];
		end
	end

	// Advance parser and system state; load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_H1;
			left_q     <= 16'd0;
			pos_q      <= 8'd0;
			cmd_q      <= 16'd0;
			mode_q     <= MODE_INIT;
			err_q      <= RST_ERR_OK;
			m_tvalid_q <= 1'b0;
		end else begin
			if (process) begin
				phase_q <= phase_d;
				left_q  <= left_d;
				pos_q   <= pos_d;
				cmd_q   <= cmd_d;
				mode_q  <= mode_d;
				err_q   <= err_d;
			end
			if (advance) begin
				m_tvalid_q <= process && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (process && res_valid) begin
			out_byte_q    <= byte_s1;
			out_idx_q     <= pos_q;
			out_last_q    <= res_last;
			out_verdict_q <= res_verdict;
			out_code_q    <= res_code;
			out_rej_q     <= res_rej;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_rej_q, out_code_q, out_idx_q, out_byte_q};
	assign m_tuser  = out_verdict_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== test/tb_command_packet_deframer.sv =====
// Self-checking testbench for the command packet deframer with a built-in predictor.
module tb_command_packet_deframer;
	import cpd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Parser position within a packet
	typedef enum logic [2:0] {
		PH_HUNT_C,
		PH_HUNT_M,
		PH_HUNT_GT,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_PAYLOAD
	} parse_phase_t;

	// System mode as set by mode events
	typedef enum logic [2:0] {
		MODE_INIT  = 3'd1,
		MODE_READY = 3'd2,
		MODE_BUSY  = 3'd3,
		MODE_ERROR = 3'd4
	} sys_mode_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [15:0] err_value;
	} stream_item_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic [7:0]  byte_index;
		logic        last;
		verdict_t    verdict;
		logic [15:0] cmd_word;
		logic [15:0] reject_code;
	} payload_item_t;

	// Register indexes that select no register
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;
	localparam int unsigned MAX_PAYLOAD = MAX_PACKET_LEN - HDR_LEN;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [23:0]          s_tdata = '0;   // data_byte[7:0], err_value[23:8]
	logic [1:0]           s_tuser = '0;   // kind[1:0]
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// payload_byte[7:0], byte_index[15:8], cmd_word[31:16], reject_code[47:32]
	logic [47:0]          m_tdata;
	logic [1:0]           m_tuser;        // verdict[1:0]
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	// Predictor state and its copy of the registers
	cpd_cfg_t cfg_shadow = '{
		allowed_first:  RST_ALLOWED,
		allowed_second: RST_ALLOWED,
		allowed_third:  RST_ALLOWED,
		err_ok:         RST_ERR_OK,
		err_busy:       RST_ERR_BUSY,
		err_general:    RST_ERR_GENERAL
	};
	parse_phase_t parse_state = PH_HUNT_C;
	logic [15:0]  bytes_left = '0;
	logic [7:0]   payload_pos = '0;
	logic [15:0]  cmd_code = '0;
	sys_mode_t    sys_mode = MODE_INIT;
	logic [15:0]  sys_error = RST_ERR_OK;

	stream_item_t  stream_queue[$];
	payload_item_t expected_payload[$];
	int unsigned   items_queued = 0;
	int unsigned   items_taken = 0;
	int unsigned   error_count = 0;

	stream_item_t  cur_item;
	int unsigned   send_gap = 0;
	int unsigned   send_calm = 0;
	int unsigned   recv_stall = 0;
	int unsigned   recv_calm = 0;

	command_packet_deframer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advance the parser by one item; return 1 when a payload item comes out
	function automatic bit deframe_step(input stream_item_t it, output payload_item_t res);
		logic [7:0] idx;
		bit         two;
		res = '0;
		case (it.kind)
			KIND_READY: begin
				sys_mode = MODE_READY;
				sys_error = cfg_shadow.err_ok;
				return 1'b0;
			end
			KIND_BUSY: begin
				sys_mode = MODE_BUSY;
				sys_error = cfg_shadow.err_busy;
				return 1'b0;
			end
			KIND_ERROR: begin
				sys_mode = MODE_ERROR;
				sys_error = (it.err_value != cfg_shadow.err_ok) ?
					it.err_value : cfg_shadow.err_general;
				return 1'b0;
			end
			default: ;
		endcase
		case (parse_state)
			PH_HUNT_C: begin
				if (it.data_byte == HDR_BYTE_C)
					parse_state = PH_HUNT_M;
			end
			// a wrong header byte is not taken as a fresh first byte
			PH_HUNT_M: parse_state = (it.data_byte == HDR_BYTE_M) ? PH_HUNT_GT : PH_HUNT_C;
			PH_HUNT_GT: parse_state = (it.data_byte == HDR_BYTE_GT) ? PH_LEN_HI : PH_HUNT_C;
			PH_LEN_HI: begin
				bytes_left = {it.data_byte, 8'h00};
				parse_state = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				bytes_left = {bytes_left[15:8], it.data_byte};
				if (bytes_left != 0 && bytes_left + HDR_LEN <= MAX_PACKET_LEN) begin
					payload_pos = '0;
					cmd_code = '0;
					parse_state = PH_PAYLOAD;
				end else begin
					parse_state = PH_HUNT_C;
				end
			end
			PH_PAYLOAD: begin
				idx = payload_pos;
				if (idx == 0)
					cmd_code[15:8] = it.data_byte;
				else if (idx == 1)
					cmd_code[7:0] = it.data_byte;
				if (payload_pos != POS_MAX)
					payload_pos = payload_pos + 8'd1;
				bytes_left = bytes_left - 16'd1;
				res.payload_byte = it.data_byte;
				res.byte_index = idx;
				res.last = (bytes_left == 0);
				res.verdict = VERDICT_MORE;
				if (res.last) begin
					two = (idx >= 1);
					if (two)
						res.cmd_word = cmd_code;
					if (sys_mode == MODE_READY || sys_mode == MODE_INIT) begin
						res.verdict = VERDICT_FWD;
					end else if (!two) begin
						res.verdict = VERDICT_DROP;
					end else if (cmd_code == cfg_shadow.allowed_first ||
							cmd_code == cfg_shadow.allowed_second ||
							cmd_code == cfg_shadow.allowed_third) begin
						res.verdict = VERDICT_FWD;
					end else begin
						res.verdict = VERDICT_REJECT;
						res.reject_code = sys_error;
					end
					parse_state = PH_HUNT_C;
				end
				return 1'b1;
			end
			default: parse_state = PH_HUNT_C;
		endcase
		return 1'b0;
	endfunction

	// Mostly short gaps, a few long ones, and now and then a calm stretch
	function automatic int unsigned pick_gap(inout int unsigned calm);
		int unsigned r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (error_count < 40)
			$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		error_count++;
	endtask

	// Feed input items and predict at each accepted one
	always @(posedge clk) begin
		payload_item_t res;
		if (s_tvalid && s_tready) begin
			if (deframe_step(cur_item, res))
				expected_payload.push_back(res);
			items_taken++;
			send_gap = pick_gap(send_calm);
		end
		if (!s_tvalid || s_tready) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (stream_queue.size() != 0) begin
				cur_item = stream_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {cur_item.err_value, cur_item.data_byte};
				s_tuser <= cur_item.kind;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Check result items against the oldest prediction; stall at random
	always @(posedge clk) begin
		payload_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_payload.size() == 0) begin
				report_mismatch("unexpected item", m_tdata[15:0], 16'h0000);
			end else begin
				want = expected_payload.pop_front();
				if (m_tdata[7:0] !== want.payload_byte)
					report_mismatch("payload_byte", m_tdata[7:0], want.payload_byte);
				if (m_tdata[15:8] !== want.byte_index)
					report_mismatch("byte_index", m_tdata[15:8], want.byte_index);
				if (m_tlast !== want.last)
					report_mismatch("last", m_tlast, want.last);
				if (m_tuser !== want.verdict)
					report_mismatch("verdict", m_tuser, want.verdict);
				if (m_tdata[31:16] !== want.cmd_word)
					report_mismatch("cmd_word", m_tdata[31:16], want.cmd_word);
				if (m_tdata[47:32] !== want.reject_code)
					report_mismatch("reject_code", m_tdata[47:32], want.reject_code);
			end
			recv_stall = pick_gap(recv_calm);
		end else if (!m_tvalid && recv_stall == 0 && $urandom_range(0, 15) == 0) begin
			recv_stall = pick_gap(recv_calm);
		end
		if (recv_stall > 0) begin
			recv_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic push_item(input kind_t k, input logic [7:0] b, input logic [15:0] ec);
		stream_item_t it;
		it.kind = k;
		it.data_byte = b;
		it.err_value = ec;
		stream_queue.push_back(it);
		items_queued++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		push_item(KIND_BYTE, b, 16'($urandom));
	endtask

	task automatic push_event(input kind_t k, input logic [15:0] ec);
		push_item(k, 8'($urandom), ec);
	endtask

	task automatic push_random_event();
		kind_t k;
		k = kind_t'($urandom_range(1, 3));
		push_event(k, ($urandom_range(0, 3) == 0) ? cfg_shadow.err_ok : 16'($urandom));
	endtask

	task automatic push_header(input int unsigned len);
		push_byte(HDR_BYTE_C);
		push_byte(HDR_BYTE_M);
		push_byte(HDR_BYTE_GT);
		push_byte(8'(len >> 8));
		push_byte(8'(len));
	endtask

	// Well-formed packet; the code is often one of the allowed ones
	task automatic push_packet(input int unsigned len);
		logic [15:0] code;
		int unsigned mid;
		case ($urandom_range(0, 4))
			0: code = cfg_shadow.allowed_first;
			1: code = cfg_shadow.allowed_second;
			2: code = cfg_shadow.allowed_third;
			default: code = 16'($urandom);
		endcase
		mid = ($urandom_range(0, 11) == 0) ? $urandom_range(0, len - 1) : len;
		push_header(len);
		for (int unsigned i = 0; i < len; i++) begin
			if (i == mid)
				push_random_event();
			if (i == 0)
				push_byte(code[15:8]);
			else if (i == 1)
				push_byte(code[7:0]);
			else
				push_byte(8'($urandom));
		end
	endtask

	task automatic push_broken_header();
		logic [7:0] wrong;
		wrong = 8'($urandom);
		push_byte(HDR_BYTE_C);
		if ($urandom_range(0, 1) == 0) begin
			if (wrong == HDR_BYTE_M)
				wrong ^= 8'h01;
			push_byte(wrong);
		end else begin
			push_byte(HDR_BYTE_M);
			if (wrong == HDR_BYTE_GT)
				wrong ^= 8'h01;
			push_byte(wrong);
		end
	endtask

	task automatic push_bad_length();
		case ($urandom_range(0, 4))
			0: push_header(0);
			1: push_header(MAX_PAYLOAD + 1);
			2: push_header(16'hFFFF);
			3: push_header(16'h0100);
			default: push_header($urandom_range(MAX_PAYLOAD + 1, 16'hFFFF));
		endcase
	endtask

	// Fill the stream with mostly good packets, plus events and noise
	task automatic fill_random(input int unsigned quota);
		int unsigned start;
		int unsigned r;
		start = items_queued;
		while (items_queued - start < quota) begin
			r = $urandom_range(0, 99);
			if (r < 62) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					push_packet($urandom_range(1, 3));
				else if (r < 90)
					push_packet($urandom_range(4, 16));
				else if (r < 99)
					push_packet($urandom_range(17, 64));
				else
					push_packet(MAX_PAYLOAD);
			end else if (r < 74) begin
				push_random_event();
			end else if (r < 82) begin
				push_broken_header();
			end else if (r < 90) begin
				repeat ($urandom_range(1, 6))
					push_byte(8'($urandom));
			end else begin
				push_bad_length();
			end
		end
	endtask

	// Edge cases at reset settings: header quirk, zero length, each verdict, events mid-packet
	task automatic run_directed();
		push_byte(HDR_BYTE_C);
		push_byte(HDR_BYTE_C);
		push_byte(HDR_BYTE_M);
		push_byte(HDR_BYTE_GT);
		push_header(1);
		push_byte(8'hFF);
		push_event(KIND_BUSY, 16'h0000);
		push_header(2);
		push_byte(8'h00);
		push_byte(8'h00);
		push_event(KIND_ERROR, cfg_shadow.err_ok);
		push_header(0);
		push_header(1);
		push_byte(8'h55);
		push_header(2);
		push_byte(8'h12);
		push_event(KIND_ERROR, 16'hFFFF);
		push_byte(8'h34);
	endtask

	task automatic wait_idle();
		while (items_taken != items_queued || expected_payload.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write one register; called at a rising edge, leaves valid high
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_ALLOWED_FIRST:  cfg_shadow.allowed_first = value;
			CFG_ALLOWED_SECOND: cfg_shadow.allowed_second = value;
			CFG_ALLOWED_THIRD:  cfg_shadow.allowed_third = value;
			CFG_ERR_OK:         cfg_shadow.err_ok = value;
			CFG_ERR_BUSY:       cfg_shadow.err_busy = value;
			CFG_ERR_GENERAL:    cfg_shadow.err_general = value;
			default: ;
		endcase
	endtask

	task automatic load_config(input logic [15:0] first, input logic [15:0] second,
			input logic [15:0] third, input logic [15:0] ok, input logic [15:0] busy,
			input logic [15:0] general);
		cfg_write(CFG_ALLOWED_FIRST, first);
		cfg_write(CFG_ALLOWED_SECOND, second);
		cfg_write(CFG_ALLOWED_THIRD, third);
		cfg_write(CFG_ERR_OK, ok);
		cfg_write(CFG_ERR_BUSY, busy);
		cfg_write(CFG_ERR_GENERAL, general);
		// writes to unused indexes must change nothing
		cfg_write(CFG_IDX_SPARE_LO, 16'($urandom));
		cfg_write(CFG_IDX_SPARE_HI, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		fill_random(200);
		wait_idle();

		load_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom));
		fill_random(160);
		wait_idle();

		load_config(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
		push_event(KIND_BUSY, 16'h0000);
		push_packet(MAX_PAYLOAD);
		fill_random(160);
		wait_idle();

		load_config(16'hFFFF, 16'h0000, 16'($urandom), 16'h0000, 16'hFFFF, 16'hFFFF);
		fill_random(160);
		wait_idle();

		if (error_count == 0)
			$display("tb_command_packet_deframer: clean");
		else
			$display("tb_command_packet_deframer: errors");
		$finish;
	end

	// Stop a hung run
	initial begin
		#5ms;
		$display("tb_command_packet_deframer: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/cpd_pkg.sv
sv/cpd_cfg_regs.sv
sv/command_packet_deframer.sv
test/tb_command_packet_deframer.sv
